// File: sv/rfsd_pkg.sv
// Package for the register frame stream decoder: result kinds, header
// constants, parse and controller state types, controller/datapath structs.
// No dependencies.
package rfsd_pkg;

   localparam int MAX_REGS_DEFAULT = 16;
   localparam int BYTE_W           = 8;
   localparam int KIND_W           = 2;
   localparam int INDEX_W          = 6;

   localparam logic [BYTE_W-1:0] MAGIC_F      = 8'h46;  // 'F'
   localparam logic [BYTE_W-1:0] MAGIC_D      = 8'h44;  // 'D'
   localparam logic [BYTE_W-1:0] FRAME_VER    = 8'h01;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   typedef enum logic [2:0] {
      PH_MAGIC0,
      PH_MAGIC1,
      PH_VERSION,
      PH_COUNT,
      PH_FRAME,
      PH_HALT
   } parse_phase_type;

   typedef enum logic [1:0] {
      CS_INPUT,
      CS_SCAN,
      CS_LOAD
   } ctl_state_type;

   typedef struct packed {
      logic accept;       // input transaction this cycle
      logic scan_step;    // skip an unmarked register
      logic emit_write;   // load a register write into the output slot
   } rfsd_cmd_type;

   typedef struct packed {
      logic frame_go;     // accepted byte completes a frame with marks
      logic hit;          // scan index points at a marked register
      logic last;         // no marks left after the current one
      logic slot_free;    // output register free at the next edge
   } rfsd_status_type;

endpackage

// File: sv/rfsd_if.sv
// Valid/ready channel interfaces for the register frame stream decoder.
// Depends on rfsd_pkg.
interface rfsd_req_if;
   logic                        valid;
   logic                        ready;
   logic [rfsd_pkg::BYTE_W-1:0] data_byte;
   logic                        file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface rfsd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rfsd_pkg::KIND_W-1:0]  kind;
   logic [rfsd_pkg::INDEX_W-1:0] reg_index;
   logic [rfsd_pkg::BYTE_W-1:0]  reg_value;
   logic                         frame_last;

   modport source (output valid, output kind, output reg_index, output reg_value,
                   output frame_last, input ready);
   modport sink   (input valid, input kind, input reg_index, input reg_value,
                   input frame_last, output ready);
endinterface

// File: sv/rfsd_ctrl.sv
// Controller for the register frame stream decoder: input acceptance and
// sequencing of the write scan at frame end. Depends on rfsd_pkg.
module rfsd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rfsd_pkg::rfsd_status_type status,
   output rfsd_pkg::rfsd_cmd_type    cmd
);
   import rfsd_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_INPUT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_INPUT: begin
            req_ready  = status.slot_free;
            cmd.accept = req_valid && status.slot_free;
            if (cmd.accept && status.frame_go) begin
               state_in = CS_SCAN;
            end
         end
         CS_SCAN: begin
            // read data for a hit is registered, so a hit goes through CS_LOAD
            if (status.hit) begin
               state_in = CS_LOAD;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         CS_LOAD: begin
            if (status.slot_free) begin
               cmd.emit_write = 1'b1;
               state_in       = status.last ? CS_INPUT : CS_SCAN;
            end
         end
         default: begin
            state_in = CS_INPUT;
         end
      endcase
   end

endmodule

// File: sv/rfsd_datapath.sv
// Datapath for the register frame stream decoder: header/frame parser,
// mark bytes, value memory, scan registers and output register.
// Depends on rfsd_pkg and rfsd_rsp_if.
module rfsd_datapath #(
   parameter int MaxRegs = rfsd_pkg::MAX_REGS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rfsd_pkg::BYTE_W-1:0] data_byte,
   input  logic                        file_start,
   input  rfsd_pkg::rfsd_cmd_type      cmd,
   output rfsd_pkg::rfsd_status_type   status,
   rfsd_rsp_if.source                  rsp
);
   import rfsd_pkg::*;

   localparam int IdxW         = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;
   localparam int CntW         = $clog2(MaxRegs + 1);
   localparam int NumMarkBytes = (MaxRegs + 7) / 8;
   localparam int MbW          = $clog2(NumMarkBytes + 1);
   localparam int MbiW         = (NumMarkBytes > 1) ? $clog2(NumMarkBytes) : 1;
   localparam int PosW         = $clog2(MaxRegs + NumMarkBytes + 1);

   parse_phase_type   phase_ff, phase_in, cur_phase;
   logic [CntW-1:0]   count_ff, count_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [BYTE_W-1:0] mark_ff [NumMarkBytes];
   logic [BYTE_W-1:0] value_mem [MaxRegs];
   logic [BYTE_W-1:0] rd_ff;
   logic [MaxRegs-1:0] scan_mask_ff;
   logic [IdxW-1:0]   idx_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0]   value_ff, value_in;
   logic                last_ff, last_in;
   logic                load;

   logic [CntW+3:0]     cnt_ext;
   logic [MbW-1:0]      mark_cnt;
   logic                in_marks;
   logic [PosW-1:0]     val_off;
   logic [IdxW-1:0]     val_idx;
   logic                frame_end;
   logic [MaxRegs-1:0]  marks_flat, count_mask, masked;
   logic [MaxRegs-1:0]  rest;
   logic                err, fdone, mark_we, val_we;
   logic                slot_free;

   // ---- frame geometry ----
   assign cnt_ext   = (CntW + 4)'(count_ff) + (CntW + 4)'(7);
   assign mark_cnt  = MbW'(cnt_ext >> 3);
   assign in_marks  = pos_ff < PosW'(mark_cnt);
   assign val_off   = pos_ff - PosW'(mark_cnt);
   assign val_idx   = IdxW'(val_off);
   assign frame_end = (val_off + PosW'(1)) == PosW'(count_ff);

   always_comb begin
      for (int j = 0; j < MaxRegs; j++) begin
         marks_flat[j] = mark_ff[j >> 3][j & 7];
         count_mask[j] = CntW'(j) < count_ff;
      end
   end
   assign masked = marks_flat & count_mask;

   // ---- parser ----
   assign cur_phase = file_start ? PH_MAGIC0 : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      err      = 1'b0;
      fdone    = 1'b0;
      mark_we  = 1'b0;
      val_we   = 1'b0;
      if (cmd.accept) begin
         phase_in = cur_phase;
         unique case (cur_phase)
            PH_MAGIC0: begin
               if (data_byte == MAGIC_F) phase_in = PH_MAGIC1;
               else err = 1'b1;
            end
            PH_MAGIC1: begin
               if (data_byte == MAGIC_D) phase_in = PH_VERSION;
               else err = 1'b1;
            end
            PH_VERSION: begin
               if (data_byte == FRAME_VER) phase_in = PH_COUNT;
               else err = 1'b1;
            end
            PH_COUNT: begin
               if (data_byte == '0 || data_byte > BYTE_W'(MaxRegs)) begin
                  err = 1'b1;
               end else begin
                  count_in = CntW'(data_byte);
                  pos_in   = '0;
                  phase_in = PH_FRAME;
               end
            end
            PH_FRAME: begin
               if (in_marks) begin
                  mark_we = 1'b1;
                  pos_in  = pos_ff + PosW'(1);
               end else begin
                  val_we = 1'b1;
                  if (frame_end) begin
                     fdone  = 1'b1;
                     pos_in = '0;
                  end else begin
                     pos_in = pos_ff + PosW'(1);
                  end
               end
            end
            PH_HALT: begin
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
         if (err) phase_in = PH_HALT;
      end
   end

   always_ff @(posedge clock) begin
      if (mark_we) mark_ff[pos_ff[MbiW-1:0]] <= data_byte;
   end

   // ---- value memory, read at the scan index ----
   always_ff @(posedge clock) begin
      if (val_we) value_mem[val_idx] <= data_byte;
      rd_ff <= value_mem[idx_ff];
   end

   // ---- scan over the marks of a finished frame ----
   assign rest = scan_mask_ff & ~(MaxRegs'(1) << idx_ff);

   always_ff @(posedge clock) begin
      if (fdone && (|masked)) begin
         scan_mask_ff <= masked;
         idx_ff       <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IdxW'(1);
      end else if (cmd.emit_write) begin
         scan_mask_ff <= rest;
         idx_ff       <= idx_ff + IdxW'(1);
      end
   end

   // ---- output register ----
   assign slot_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      load     = 1'b0;
      kind_in  = KIND_WRITE;
      index_in = '0;
      value_in = '0;
      last_in  = 1'b1;
      if (err) begin
         load    = 1'b1;
         kind_in = KIND_ERROR;
      end else if (fdone && !(|masked)) begin
         load    = 1'b1;
         kind_in = KIND_EMPTY;
      end else if (cmd.emit_write) begin
         load     = 1'b1;
         index_in = INDEX_W'(idx_ff);
         value_in = rd_ff;
         last_in  = rest == '0;
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         index_ff <= index_in;
         value_ff <= value_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = kind_ff;
   assign rsp.reg_index  = index_ff;
   assign rsp.reg_value  = value_ff;
   assign rsp.frame_last = last_ff;

   assign status.frame_go  = fdone && (|masked);
   assign status.hit       = scan_mask_ff[idx_ff];
   assign status.last      = rest == '0;
   assign status.slot_free = slot_free;

endmodule

// File: sv/register_frame_stream_decoder.sv
// channel | dir | fields                                       | transaction
// req_bus | in  | data_byte[7:0], file_start                   | valid && ready
// rsp_bus | out | kind[1:0], reg_index[5:0], reg_value[7:0],   | valid && ready
//         |     | frame_last                                   |
// At frame end the mark vector is scanned in register order: an unmarked
// register is skipped, and a marked one passes through CS_LOAD for the
// registered value memory read. Input resumes once the last write is loaded.
// Reset is synchronous and clears the parser and controller; the value memory
// is never cleared. A stalled result holds the output register, and input
// also waits while that register cannot take a new result.
// Top level; depends on rfsd_pkg, rfsd_if, rfsd_ctrl, rfsd_datapath.
module register_frame_stream_decoder #(
   parameter int MaxRegs = rfsd_pkg::MAX_REGS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rfsd_req_if.sink   req_bus,
   rfsd_rsp_if.source rsp_bus
);
   import rfsd_pkg::*;

   rfsd_cmd_type    cmd;
   rfsd_status_type status;
   logic            ready;

   rfsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   rfsd_datapath #(.MaxRegs(MaxRegs)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_bus.data_byte),
      .file_start (req_bus.file_start),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp_bus)
   );

   assign req_bus.ready = ready;

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind != KIND_WRITE) |-> rsp_bus.frame_last)
      else $error("non-write result without frame_last");

   a_non_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind != KIND_WRITE)
         |-> (rsp_bus.reg_index == '0 && rsp_bus.reg_value == '0))
      else $error("non-write result carries index or value");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_WRITE)
         |-> (32'(rsp_bus.reg_index) < 32'(MaxRegs)))
      else $error("write index out of range");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready)
         |=> (rsp_bus.valid && $stable({rsp_bus.kind, rsp_bus.reg_index,
                                        rsp_bus.reg_value, rsp_bus.frame_last})))
      else $error("stalled result changed");

endmodule
